// File: src/lsrc_pkg.sv
// Shared constants and width helpers for the laser stripe row centroid block.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package lsrc_pkg;

    localparam int PIXEL_W         = 8;
    localparam int CENTROID_W      = 20;
    localparam int ROW_IDX_W       = 11;
    localparam int FRAC_W          = 8;
    localparam int S_TDATA_W       = 8;
    localparam int M_TDATA_W       = 32;
    localparam int MAX_WIDTH_DEF   = 2048;
    localparam int MAX_ROWS_DEF    = 2048;
    localparam int FIFO_DEPTH      = 4;
    localparam logic [PIXEL_W-1:0] THRESHOLD_RESET = 8'd127;

    // Column counter must hold MAX_WIDTH itself (saturated state).
    function automatic int col_width(input int max_width);
        return $clog2(max_width + 1);
    endfunction

    // Largest weighted sum: every pixel 255 on every column of a full row.
    function automatic int wsum_width(input int max_width);
        longint wmax;
        wmax = 64'(255) * longint'(max_width) * longint'(max_width + 1) / 2;
        return $clog2(wmax + 1);
    endfunction

    function automatic int isum_width(input int max_width);
        longint imax;
        imax = 64'(255) * longint'(max_width);
        return $clog2(imax + 1);
    endfunction

    // The centroid never exceeds the last column, so the quotient is bounded.
    function automatic int quo_width(input int max_width);
        longint qmax;
        qmax = longint'(max_width) * 64'(256);
        return $clog2(qmax + 1);
    endfunction

    function automatic int row_width(input int max_rows);
        return (max_rows > 1) ? $clog2(max_rows) : 1;
    endfunction

endpackage

`default_nettype wire

// File: src/lsrc_front.sv
// Front end: threshold register, per-row weighted and intensity accumulation.
// Emits one request per finished row that had a bright pixel. Uses lsrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsrc_front #(
    parameter int MAX_WIDTH = lsrc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_ROWS  = lsrc_pkg::MAX_ROWS_DEF,
    parameter int REC_W     = 64
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [lsrc_pkg::PIXEL_W-1:0] cfg_wr_data,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [lsrc_pkg::PIXEL_W-1:0] pixel,
    input  wire logic                         end_of_row,
    input  wire logic                         end_of_frame,
    input  wire logic                         q_full,
    output logic                              q_push,
    output logic [REC_W-1:0]                  q_data
);

    localparam int CW  = lsrc_pkg::col_width(MAX_WIDTH);
    localparam int WSW = lsrc_pkg::wsum_width(MAX_WIDTH);
    localparam int ISW = lsrc_pkg::isum_width(MAX_WIDTH);
    localparam int RW  = lsrc_pkg::row_width(MAX_ROWS);
    localparam int PW  = lsrc_pkg::PIXEL_W;

    logic [PW-1:0]  thr_reg;
    logic [CW-1:0]  col_reg, col_next;
    logic [WSW-1:0] ws_reg, ws_next;
    logic [ISW-1:0] is_reg, is_next;
    logic [RW-1:0]  row_reg, row_next;

    logic           accept;
    logic           in_range;
    logic           bright;
    logic           row_done;
    logic [CW-1:0]  col_inc;
    logic [PW+CW-1:0] prod;
    logic [WSW-1:0] ws_sum;
    logic [ISW-1:0] is_sum;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign row_done = end_of_row || end_of_frame;
    assign in_range = (col_reg < CW'(MAX_WIDTH));
    assign bright   = in_range && (pixel > thr_reg);
    assign col_inc  = col_reg + CW'(1);
    assign prod     = (PW+CW)'(pixel) * (PW+CW)'(col_inc);

    always_comb begin
        ws_sum = ws_reg;
        is_sum = is_reg;
        if (bright) begin
            ws_sum = ws_reg + WSW'(prod);
            is_sum = is_reg + ISW'(pixel);
        end
    end

    assign q_push = accept && row_done && (is_sum != '0);
    assign q_data = REC_W'({row_reg, is_sum, ws_sum});

    always_comb begin
        col_next = col_reg;
        ws_next  = ws_reg;
        is_next  = is_reg;
        row_next = row_reg;
        if (accept) begin
            if (row_done) begin
                col_next = '0;
                ws_next  = '0;
                is_next  = '0;
                if (end_of_frame) begin
                    row_next = '0;
                end else if (row_reg < RW'(MAX_ROWS - 1)) begin
                    row_next = row_reg + RW'(1);
                end
            end else begin
                ws_next = ws_sum;
                is_next = is_sum;
                if (in_range) begin
                    col_next = col_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= lsrc_pkg::THRESHOLD_RESET;
            col_reg <= '0;
            ws_reg  <= '0;
            is_reg  <= '0;
            row_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
            col_reg <= col_next;
            ws_reg  <= ws_next;
            is_reg  <= is_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

// File: src/lsrc_fifo.sv
// Short request queue between the row accumulator and the divider.
// Holds finished row sums; uses the depth constant from lsrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsrc_fifo #(
    parameter int DATA_W = 64
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic                   not_empty,
    output logic [DATA_W-1:0]      pop_data
);

    localparam int DEPTH = lsrc_pkg::FIFO_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: src/lsrc_div.sv
// Back end: radix-2 restoring divider producing the Q.8 centroid, plus the
// output register of the result stream. Uses width helpers from lsrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsrc_div #(
    parameter int MAX_WIDTH = lsrc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_ROWS  = lsrc_pkg::MAX_ROWS_DEF,
    parameter int REC_W     = 64
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            q_not_empty,
    input  wire logic [REC_W-1:0]                q_data,
    output logic                                 q_pop,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [lsrc_pkg::CENTROID_W-1:0]      centroid_q8,
    output logic [lsrc_pkg::ROW_IDX_W-1:0]       row_index
);

    localparam int WSW = lsrc_pkg::wsum_width(MAX_WIDTH);
    localparam int ISW = lsrc_pkg::isum_width(MAX_WIDTH);
    localparam int RW  = lsrc_pkg::row_width(MAX_ROWS);
    localparam int QW  = lsrc_pkg::quo_width(MAX_WIDTH);
    localparam int NW  = WSW + lsrc_pkg::FRAC_W;
    localparam int SW  = (QW > 1) ? $clog2(QW) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t         state_reg;
    logic [SW-1:0]  step_reg;
    logic [ISW-1:0] rem_reg;
    logic [QW-1:0]  quo_reg;
    logic [ISW-1:0] den_reg;
    logic [RW-1:0]  row_reg;
    logic           out_valid_reg;
    logic [lsrc_pkg::CENTROID_W-1:0] out_cent_reg;
    logic [lsrc_pkg::ROW_IDX_W-1:0]  out_row_reg;

    logic [WSW-1:0] rec_ws;
    logic [ISW-1:0] rec_is;
    logic [RW-1:0]  rec_row;
    logic [NW-1:0]  dividend;
    logic [ISW:0]   trial;
    logic [ISW:0]   diff;
    logic           ge;
    logic           slot_free;

    assign rec_ws   = q_data[WSW-1:0];
    assign rec_is   = q_data[WSW+ISW-1:WSW];
    assign rec_row  = q_data[WSW+ISW+RW-1:WSW+ISW];
    assign dividend = {rec_ws, {lsrc_pkg::FRAC_W{1'b0}}};

    // The quotient fits in QW bits, so the bits above it are already below the divisor.
    assign trial = {rem_reg, quo_reg[QW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    assign slot_free = !out_valid_reg || m_tready;
    assign q_pop     = (state_reg == ST_IDLE) && q_not_empty;

    assign m_tvalid    = out_valid_reg;
    assign centroid_q8 = out_cent_reg;
    assign row_index   = out_row_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if ((state_reg == ST_DONE) && slot_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_not_empty) begin
                        rem_reg   <= ISW'(dividend >> QW);
                        quo_reg   <= dividend[QW-1:0];
                        den_reg   <= rec_is;
                        row_reg   <= rec_row;
                        step_reg  <= SW'(QW - 1);
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    rem_reg <= ge ? diff[ISW-1:0] : trial[ISW-1:0];
                    quo_reg <= {quo_reg[QW-2:0], ge};
                    if (step_reg == '0) begin
                        state_reg <= ST_DONE;
                    end else begin
                        step_reg <= step_reg - SW'(1);
                    end
                end
                ST_DONE: begin
                    if (slot_free) begin
                        out_cent_reg  <= lsrc_pkg::CENTROID_W'(quo_reg);
                        out_row_reg   <= lsrc_pkg::ROW_IDX_W'(row_reg);
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: src/laser_stripe_row_centroid.sv
// Pixels are taken at one per clock while the row queue has room. Each row
// with at least one pixel above the threshold leaves a request in a
// four-entry queue; a radix-2 restoring divider turns it into a Q.8
// centroid. The divider works on one request at a time; rows that end
// while it is busy are buffered by the queue, and the input stalls only
// while the queue is full.
// Top level; depends on lsrc_pkg, lsrc_front, lsrc_fifo and lsrc_div.
`timescale 1ns / 1ps
`default_nettype none

module laser_stripe_row_centroid #(
    parameter int MAX_WIDTH = lsrc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_ROWS  = lsrc_pkg::MAX_ROWS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [lsrc_pkg::PIXEL_W-1:0]   cfg_wr_data,  // threshold
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [lsrc_pkg::S_TDATA_W-1:0] s_tdata,      // [7:0] pixel
    input  wire logic                           s_tlast,      // end_of_row
    input  wire logic                           s_tuser,      // [0] end_of_frame
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [lsrc_pkg::M_TDATA_W-1:0]      m_tdata       // [19:0] centroid_q8,
                                                              // [30:20] row_index
);

    localparam int WSW   = lsrc_pkg::wsum_width(MAX_WIDTH);
    localparam int ISW   = lsrc_pkg::isum_width(MAX_WIDTH);
    localparam int RW    = lsrc_pkg::row_width(MAX_ROWS);
    localparam int REC_W = WSW + ISW + RW;

    logic             q_full;
    logic             q_push;
    logic [REC_W-1:0] q_wdata;
    logic             q_pop;
    logic             q_not_empty;
    logic [REC_W-1:0] q_rdata;
    logic [lsrc_pkg::CENTROID_W-1:0] centroid_q8;
    logic [lsrc_pkg::ROW_IDX_W-1:0]  row_index;

    lsrc_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_ROWS  (MAX_ROWS),
        .REC_W     (REC_W)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .pixel        (s_tdata[lsrc_pkg::PIXEL_W-1:0]),
        .end_of_row   (s_tlast),
        .end_of_frame (s_tuser),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_wdata)
    );

    lsrc_fifo #(
        .DATA_W (REC_W)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_rdata)
    );

    lsrc_div #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_ROWS  (MAX_ROWS),
        .REC_W     (REC_W)
    ) u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_data      (q_rdata),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .centroid_q8 (centroid_q8),
        .row_index   (row_index)
    );

    assign m_tdata = lsrc_pkg::M_TDATA_W'({row_index, centroid_q8});

endmodule

`default_nettype wire

// File: verif/centroid_checker.sv
// Checker for the laser stripe row centroid block: watches the threshold port and both streams,
// predicts each row's centroid and compares it with what the block emits.
// Depends on lsrc_pkg for widths and the threshold reset value.
`timescale 1ns / 1ps

module centroid_checker #(
    parameter int MAX_WIDTH = lsrc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_ROWS  = lsrc_pkg::MAX_ROWS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [lsrc_pkg::PIXEL_W-1:0]   cfg_wr_data,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [lsrc_pkg::S_TDATA_W-1:0] s_tdata,      // [7:0] pixel
    input  logic                           s_tlast,      // end_of_row
    input  logic                           s_tuser,      // [0] end_of_frame
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [lsrc_pkg::M_TDATA_W-1:0] m_tdata,      // [19:0] centroid_q8, [30:20] row_index
    output int                             pending,
    output int                             fail_count
);

    import lsrc_pkg::*;

    localparam int COL_W  = col_width(MAX_WIDTH);
    localparam int WSUM_W = wsum_width(MAX_WIDTH);
    localparam int ISUM_W = isum_width(MAX_WIDTH);
    localparam int ROW_W  = row_width(MAX_ROWS);

    typedef struct packed {
        logic [CENTROID_W-1:0] centroid_q8;
        logic [ROW_IDX_W-1:0]  row_index;
    } row_centroid_t;

    row_centroid_t       centroid_expect[$];
    logic [PIXEL_W-1:0]  threshold;
    logic [COL_W-1:0]    column_count;
    logic [WSUM_W-1:0]   weighted_sum;
    logic [ISUM_W-1:0]   intensity_sum;
    logic [ROW_W-1:0]    row_count;
    int                  errors   = 0;

    task automatic accumulate_pixel(input logic [PIXEL_W-1:0] pix, input logic row_end,
                                    input logic frame_end);
        longint unsigned quotient;
        row_centroid_t   res;
        // Pixels past the widest row still carry their end markers.
        if (column_count < COL_W'(MAX_WIDTH)) begin
            if (pix > threshold) begin
                weighted_sum  = weighted_sum + WSUM_W'(pix) * WSUM_W'(column_count + 1'b1);
                intensity_sum = intensity_sum + ISUM_W'(pix);
            end
            column_count = column_count + 1'b1;
        end
        if (row_end || frame_end) begin
            if (intensity_sum != '0) begin
                quotient = (64'(weighted_sum) << FRAC_W) / 64'(intensity_sum);
                res.centroid_q8 = quotient[CENTROID_W-1:0];
                res.row_index   = ROW_IDX_W'(row_count);
                centroid_expect.insert(centroid_expect.size(), res);
            end
            column_count  = '0;
            weighted_sum  = '0;
            intensity_sum = '0;
            if (frame_end) begin
                row_count = '0;
            end else if (row_count < ROW_W'(MAX_ROWS - 1)) begin
                row_count = row_count + 1'b1;
            end
        end
    endtask

    task automatic check_result(input logic [M_TDATA_W-1:0] word);
        row_centroid_t         want;
        logic [CENTROID_W-1:0] got_centroid;
        logic [ROW_IDX_W-1:0]  got_row;
        got_centroid = word[CENTROID_W-1:0];
        got_row      = word[CENTROID_W +: ROW_IDX_W];
        if (centroid_expect.size() == 0) begin
            $error("unexpected result: centroid_q8 %0d, row_index %0d", got_centroid, got_row);
            errors++;
        end else begin
            want = centroid_expect.pop_front();
            if (got_centroid !== want.centroid_q8) begin
                $error("centroid_q8 mismatch: expected %0d, actual %0d",
                       want.centroid_q8, got_centroid);
                errors++;
            end
            if (got_row !== want.row_index) begin
                $error("row_index mismatch: expected %0d, actual %0d", want.row_index, got_row);
                errors++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            threshold     = THRESHOLD_RESET;
            column_count  = '0;
            weighted_sum  = '0;
            intensity_sum = '0;
            row_count     = '0;
            centroid_expect.delete();
        end else begin
            if (cfg_wr_en) begin
                threshold = cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                accumulate_pixel(s_tdata[PIXEL_W-1:0], s_tlast, s_tuser);
            end
            if (m_tvalid && m_tready) begin
                check_result(m_tdata);
            end
        end
        pending    <= centroid_expect.size();
        fail_count <= errors;
    end

endmodule

// File: verif/testbench.sv
// Top of the testbench: clock, reset, pixel stimulus, result back-pressure and the verdict.
// Depends on lsrc_pkg, the laser_stripe_row_centroid block and centroid_checker.
`timescale 1ns / 1ps

module testbench;

    import lsrc_pkg::*;

    localparam int MAX_WIDTH       = MAX_WIDTH_DEF;
    localparam int MAX_ROWS        = MAX_ROWS_DEF;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int PRESSURE_CYCLES = 400;
    localparam int RANDOM_ITEMS    = 600;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [PIXEL_W-1:0]     cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;      // [7:0] pixel
    logic                   s_tlast;      // end_of_row
    logic                   s_tuser;      // [0] end_of_frame
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;      // [19:0] centroid_q8, [30:20] row_index
    int                     pending;
    int                     fail_count;
    int                     cycles = 0;
    logic                   no_idle = 1'b0;
    logic                   pressure_req = 1'b0;

    laser_stripe_row_centroid #(.MAX_WIDTH(MAX_WIDTH), .MAX_ROWS(MAX_ROWS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tlast(s_tlast), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    centroid_checker #(.MAX_WIDTH(MAX_WIDTH), .MAX_ROWS(MAX_ROWS)) u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tlast(s_tlast), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .pending(pending), .fail_count(fail_count)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input logic row_end,
                              input logic frame_end);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tlast  <= row_end;
        s_tuser  <= frame_end;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Rows without a bright pixel give no result, so a fixed pause covers them.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [PIXEL_W-1:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin : receiver
        int hold;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (pressure_req) begin
                hold = PRESSURE_CYCLES;
                pressure_req = 1'b0;
            end else begin
                hold = no_idle ? 0 : $urandom_range(0, 9);
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    initial begin : stimulus
        int               col;
        int               p;
        int               len;
        int               centre;
        int               spread;
        int               thr;
        int               items;
        logic             noise;
        logic             frame;
        logic             row_mark;
        logic [PIXEL_W-1:0] pix;

        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        s_tuser     = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset threshold: the value at the threshold itself does not count.
        send_pixel(8'd127, 1'b0, 1'b0);
        send_pixel(8'd128, 1'b0, 1'b0);
        send_pixel(8'd0, 1'b0, 1'b0);
        send_pixel(8'd255, 1'b1, 1'b0);
        send_pixel(8'd0, 1'b0, 1'b0);
        send_pixel(8'd127, 1'b1, 1'b0);
        send_pixel(8'd255, 1'b1, 1'b1);
        // A frame end without a row end still closes the row.
        send_pixel(8'd200, 1'b0, 1'b0);
        send_pixel(8'd10, 1'b0, 1'b0);
        send_pixel(8'd130, 1'b0, 1'b1);
        send_pixel(8'd128, 1'b1, 1'b0);
        write_threshold(8'd0);
        send_pixel(8'd1, 1'b0, 1'b0);
        send_pixel(8'd0, 1'b0, 1'b0);
        send_pixel(8'd255, 1'b1, 1'b0);
        write_threshold(8'd255);
        send_pixel(8'd255, 1'b0, 1'b0);
        send_pixel(8'd254, 1'b1, 1'b1);

        items = 0;
        for (p = 0; items < RANDOM_ITEMS; p++) begin
            case (p % 6)
                0: thr = $urandom_range(0, 255);
                1: thr = 0;
                2: thr = 255;
                default: thr = $urandom_range(1, 254);
            endcase
            write_threshold(PIXEL_W'(thr));
            if (p % 6 == 1) begin
                // Hold the result side off while short bright rows keep coming.
                pressure_req = 1'b1;
                no_idle = 1'b1;
                repeat (40) send_pixel(8'd255, 1'b1, 1'b0);
                items += 40;
            end
            no_idle = (p % 3 == 1);
            repeat (8) begin
                len      = $urandom_range(1, 24);
                centre   = $urandom_range(1, len);
                spread   = $urandom_range(0, 3);
                noise    = ($urandom_range(0, 99) < 15);
                frame    = ($urandom_range(0, 9) == 0);
                row_mark = frame ? 1'($urandom_range(0, 1)) : 1'b1;
                for (col = 1; col <= len; col++) begin
                    if (noise) begin
                        pix = PIXEL_W'($urandom_range(0, 255));
                    end else if (col >= centre - spread && col <= centre + spread) begin
                        pix = PIXEL_W'($urandom_range(thr, 255));
                    end else begin
                        pix = PIXEL_W'($urandom_range(0, thr));
                    end
                    send_pixel(pix, (col == len) && row_mark, (col == len) && frame);
                end
                items += len;
            end
        end
        no_idle = 1'b0;

        wait_idle();
        repeat (60) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
